// ===== sv/wsd_pkg.sv =====
// Package for the WebSocket frame deframer: beat payload types, result bundle,
// opcode and class codes, and the opcode-to-class decoder. No dependencies.
`default_nettype none

package wsd_pkg;

    // Opcodes that get a class of their own
    localparam logic [3:0] OP_TEXT  = 4'h1;
    localparam logic [3:0] OP_CLOSE = 4'h8;
    localparam logic [3:0] OP_PING  = 4'h9;
    localparam logic [3:0] OP_PONG  = 4'hA;

    // Frame class codes
    localparam logic [2:0] CLS_TEXT  = 3'd0;
    localparam logic [2:0] CLS_CLOSE = 3'd1;
    localparam logic [2:0] CLS_PING  = 3'd2;
    localparam logic [2:0] CLS_PONG  = 3'd3;
    localparam logic [2:0] CLS_OTHER = 3'd4;

    // Input action codes
    localparam logic ACT_BYTE    = 1'b0;
    localparam logic ACT_RESTART = 1'b1;

    typedef struct packed {
        logic       action;
        logic [7:0] rx_byte;
    } t_wsd_in;

    typedef struct packed {
        logic [3:0] frame_opcode;
        logic [2:0] frame_class;
        logic       has_byte;
        logic [7:0] payload_byte;
        logic       last_of_frame;
    } t_wsd_out;

    // Parser to output stage: one result, qualified by valid
    typedef struct packed {
        logic     valid;
        t_wsd_out data;
    } t_wsd_res;

    function automatic logic [2:0] class_of(input logic [3:0] op);
        logic [2:0] cls;
        unique case (op)
            OP_TEXT:  cls = CLS_TEXT;
            OP_CLOSE: cls = CLS_CLOSE;
            OP_PING:  cls = CLS_PING;
            OP_PONG:  cls = CLS_PONG;
            default:  cls = CLS_OTHER;
        endcase
        return cls;
    endfunction

endpackage

`default_nettype wire

// ===== sv/wsd_parser.sv =====
// Frame header parser and payload unmasker for the WebSocket deframer.
// Holds all frame state; result is combinational from state and the beat.
// Depends on wsd_pkg.
`default_nettype none

module wsd_parser (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_accept,
    input  wire wsd_pkg::t_wsd_in i_in,
    output wsd_pkg::t_wsd_res     o_res
);

    localparam logic [2:0] PH_HDR0    = 3'd0;
    localparam logic [2:0] PH_HDR1    = 3'd1;
    localparam logic [2:0] PH_EXTLEN  = 3'd2;
    localparam logic [2:0] PH_MASK    = 3'd3;
    localparam logic [2:0] PH_PAYLOAD = 3'd4;

    logic [2:0]  r_phase,    n_phase;
    logic [3:0]  r_opcode,   n_opcode;
    logic        r_masked,   n_masked;
    logic [3:0]  r_len_left, n_len_left;
    logic [2:0]  r_key_left, n_key_left;
    logic [63:0] r_remain,   n_remain;
    logic [31:0] r_key,      n_key;
    logic [1:0]  r_key_idx,  n_key_idx;

    logic [7:0]  b;
    logic [6:0]  len7;
    logic        len_done;     // length known this beat
    logic        hdr_done;     // header complete this beat
    logic        use_mask;
    logic [63:0] hdr_len;
    logic [7:0]  key_byte;

    assign b = i_in.rx_byte;

    always_comb begin
        n_phase    = r_phase;
        n_opcode   = r_opcode;
        n_masked   = r_masked;
        n_len_left = r_len_left;
        n_key_left = r_key_left;
        n_remain   = r_remain;
        n_key      = r_key;
        n_key_idx  = r_key_idx;
        len7       = b[6:0];
        len_done   = 1'b0;
        hdr_done   = 1'b0;
        use_mask   = r_masked;
        hdr_len    = r_remain;
        key_byte   = 8'h00;

        o_res.valid              = 1'b0;
        o_res.data.frame_opcode  = r_opcode;
        o_res.data.frame_class   = wsd_pkg::class_of(r_opcode);
        o_res.data.has_byte      = 1'b0;
        o_res.data.payload_byte  = 8'h00;
        o_res.data.last_of_frame = 1'b0;

        if (i_in.action == wsd_pkg::ACT_RESTART) begin
            n_phase    = PH_HDR0;
            n_opcode   = '0;
            n_masked   = 1'b0;
            n_len_left = '0;
            n_key_left = '0;
            n_remain   = '0;
            n_key      = '0;
            n_key_idx  = '0;
        end else begin
            unique case (r_phase)
                PH_HDR1: begin
                    n_masked = b[7];
                    use_mask = b[7];
                    if (len7 == 7'd126 || len7 == 7'd127) begin
                        n_len_left = (len7 == 7'd126) ? 4'd2 : 4'd8;
                        n_remain   = '0;
                        n_phase    = PH_EXTLEN;
                    end else begin
                        n_remain = {57'd0, len7};
                        hdr_len  = {57'd0, len7};
                        len_done = 1'b1;
                    end
                end
                PH_EXTLEN: begin
                    n_remain = {r_remain[55:0], b};
                    hdr_len  = {r_remain[55:0], b};
                    if (r_len_left != '0) begin
                        n_len_left = r_len_left - 4'd1;
                    end
                    len_done = (n_len_left == '0);
                end
                PH_MASK: begin
                    n_key = {r_key[23:0], b};
                    if (r_key_left != '0) begin
                        n_key_left = r_key_left - 3'd1;
                    end
                    hdr_done = (n_key_left == '0);
                end
                PH_PAYLOAD: begin
                    // key byte 0 sits in the top of the key word
                    case (r_key_idx)
                        2'd0:    key_byte = r_key[31:24];
                        2'd1:    key_byte = r_key[23:16];
                        2'd2:    key_byte = r_key[15:8];
                        default: key_byte = r_key[7:0];
                    endcase
                    if (!r_masked) begin
                        key_byte = 8'h00;
                    end
                    n_key_idx = r_key_idx + 2'd1;
                    if (r_remain != '0) begin
                        n_remain = r_remain - 64'd1;
                    end
                    o_res.valid             = 1'b1;
                    o_res.data.has_byte     = 1'b1;
                    o_res.data.payload_byte = b ^ key_byte;
                    if (n_remain == '0) begin
                        n_phase                  = PH_HDR0;
                        o_res.data.last_of_frame = 1'b1;
                    end
                end
                default: begin
                    // first header byte; unused codes land here too
                    n_opcode = b[3:0];
                    n_phase  = PH_HDR1;
                end
            endcase

            if (len_done) begin
                if (use_mask) begin
                    n_key_left = 3'd4;
                    n_key      = '0;
                    n_phase    = PH_MASK;
                end else begin
                    hdr_done = 1'b1;
                end
            end

            if (hdr_done) begin
                n_key_idx = '0;
                if (hdr_len == '0) begin
                    // empty frame: one result with no byte
                    n_phase                  = PH_HDR0;
                    o_res.valid              = 1'b1;
                    o_res.data.last_of_frame = 1'b1;
                end else begin
                    n_phase = PH_PAYLOAD;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_HDR0;
            r_opcode   <= '0;
            r_masked   <= 1'b0;
            r_len_left <= '0;
            r_key_left <= '0;
            r_remain   <= '0;
            r_key      <= '0;
            r_key_idx  <= '0;
        end else if (i_accept) begin
            r_phase    <= n_phase;
            r_opcode   <= n_opcode;
            r_masked   <= n_masked;
            r_len_left <= n_len_left;
            r_key_left <= n_key_left;
            r_remain   <= n_remain;
            r_key      <= n_key;
            r_key_idx  <= n_key_idx;
        end
    end

endmodule

`default_nettype wire

// ===== sv/websocket_frame_deframer.sv =====
// WebSocket deframer; results are registered, and only payload bytes and
// empty frames give results; 1 beat per cycle while the skid is empty.
// A 2-entry output stage (result register + skid register) decouples the
// sides: o_in_ready depends only on skid occupancy, never on i_out_ready.
// Reset (synchronous, i_rst_n low) returns the parser to frame start and
// empties the output stage.
`default_nettype none

module websocket_frame_deframer (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    // input beats
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire wsd_pkg::t_wsd_in  i_in_data,
    // result beats
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    output wsd_pkg::t_wsd_out      o_out_data
);

    logic              accept;
    logic              out_free;
    wsd_pkg::t_wsd_res res;

    logic              r_out_valid,  n_out_valid;
    logic              r_skid_valid, n_skid_valid;
    wsd_pkg::t_wsd_out r_out,        n_out;
    wsd_pkg::t_wsd_out r_skid,       n_skid;

    // Ready is registered: skid empty means room for one more result.
    assign o_in_ready = !r_skid_valid;
    assign accept     = i_in_valid && o_in_ready;
    // Output register empties this cycle, or already is empty
    assign out_free   = !r_out_valid || i_out_ready;

    // Header parsing, length counting and unmasking
    wsd_parser u_parser (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_in     (i_in_data),
        .o_res    (res)
    );

    // Output stage steering. While the skid is full no beat is accepted,
    // so a held skid result always drains ahead of any newer one.
    always_comb begin
        n_out_valid  = r_out_valid;
        n_out        = r_out;
        n_skid_valid = r_skid_valid;
        n_skid       = r_skid;
        if (out_free) begin
            if (r_skid_valid) begin
                n_out        = r_skid;
                n_out_valid  = 1'b1;
                n_skid_valid = 1'b0;
            end else if (accept && res.valid) begin
                n_out       = res.data;
                n_out_valid = 1'b1;
            end else begin
                n_out_valid = 1'b0;
            end
        end else if (accept && res.valid) begin
            // result waits downstream: park the new one
            n_skid       = res.data;
            n_skid_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    // payload registers carry no reset
    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_skid <= n_skid;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

`default_nettype wire

// ===== sv/wsd_checker.sv =====
// Port-level checker for the WebSocket deframer, bound to the top level.
// Depends on wsd_pkg and websocket_frame_deframer.
`default_nettype none

module wsd_checker (
    input wire logic              i_clk,
    input wire logic              i_rst_n,
    input wire logic              o_out_valid,
    input wire logic              i_out_ready,
    input wire wsd_pkg::t_wsd_out o_out_data
);

    // stalled result beat stays
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("result beat dropped or changed under stall");

    // an empty-frame beat carries no byte and closes the frame
    a_empty_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.has_byte |->
            o_out_data.last_of_frame && o_out_data.payload_byte == 8'h00)
        else $error("empty-frame beat malformed");

    // class always follows the opcode
    a_class: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |->
            o_out_data.frame_class == wsd_pkg::class_of(o_out_data.frame_opcode))
        else $error("frame class does not match opcode");

    // nothing is presented right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

bind websocket_frame_deframer wsd_checker u_wsd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);

`default_nettype wire
